### src/bil_pkg.sv
// bucketed interval lookup: shared constants, types and the request struct
// no dependencies
package bil_pkg;
	localparam int TimeBits = 48;
	localparam int IdxBits = 10;
	localparam int MaxIntervals = 1024;
	localparam int MaxBuckets = 1024;
	localparam int CntBits = 11;
	localparam int QDepth = 4;
	localparam int QBits = 2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_NOMAP = 2'd3;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic kind;
		logic [TimeBits-1:0] a;
		logic [TimeBits-1:0] b;
		logic last;
	} req_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD0, S_RDLAST, S_DIV, S_MAPRD, S_MAPCMP,
		S_QRD, S_QDIV, S_QMAP, S_QMAPW, S_SRD, S_SCMP, S_OUT
	} state_t;
endpackage

### src/bucketed_interval_lookup_unit.sv
// A query runs a 48-step bit-serial divider to set the bucket, then one table read per
// interval visited; a time outside the span skips the divider, as does an empty map.
// A valid load writes the table; the last load also builds the map: the divider sets
// the bucket count, then a pass over the buckets and intervals fills it. Items queue
// four deep while the engine works.
// top level: depends on bil_pkg, bil_front, bil_engine
module bucketed_interval_lookup_unit import bil_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	input logic [143:0] s_tdata, // interval_start, interval_end, query_time
	input logic s_tlast, // last_interval
	input logic s_tuser, // req_type
	output logic m_tvalid,
	input logic m_tready,
	output logic [15:0] m_tdata, // status, interval_index, found
	output logic m_tlast
);
	req_t in_req, q_req;
	logic q_valid, q_pop;
	logic [1:0] st;
	logic [IdxBits-1:0] idx;
	logic fnd;

	always_comb begin
		in_req.kind = s_tuser;
		in_req.last = s_tlast;
		in_req.a = (s_tuser == REQ_QUERY) ? s_tdata[143:96] : s_tdata[47:0];
		in_req.b = s_tdata[95:48];
	end

	bil_front u_front (.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready),
		.in_req, .q_valid, .q_pop, .q_req);

	bil_engine u_engine (.clk, .arst_n, .q_valid, .q_pop, .q_req,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_status(st),
		.out_index(idx), .out_found(fnd));

	assign m_tdata = {3'b000, fnd, idx, st};
	assign m_tlast = 1'b1;
endmodule

### src/bil_front.sv
// bucketed interval lookup: input item queue between the port and the engine
// depends on bil_pkg
module bil_front import bil_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input req_t in_req,
	output logic q_valid,
	input logic q_pop,
	output req_t q_req
);
	req_t mem_q [QDepth];
	logic [QBits-1:0] wp_q, rp_q;
	logic [QBits:0] cnt_q;
	logic push;

	assign in_ready = (cnt_q != QBits'(0) + (QBits+1)'(QDepth));
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != '0);
	assign q_req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QBits+1)'(push) - (QBits+1)'(q_pop);
		end
	end
endmodule

### src/bil_engine.sv
// bucketed interval lookup: table, bucket map, shared divider and search sequencer
// depends on bil_pkg
module bil_engine import bil_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	output logic q_pop,
	input req_t q_req,
	output logic out_valid,
	input logic out_ready,
	output logic [1:0] out_status,
	output logic [IdxBits-1:0] out_index,
	output logic out_found
);
	logic [TimeBits-1:0] start_mem [MaxIntervals];
	logic [TimeBits-1:0] end_mem [MaxIntervals];
	logic [IdxBits-1:0] map_mem [MaxBuckets];

	state_t state_q, state_d;
	logic [CntBits-1:0] count_q, mapsz_q;
	logic [TimeBits-1:0] longest_q, span_q, s0_q, t_q, bnd_q;
	logic ready_q;
	logic [TimeBits-1:0] rd_s, rd_e;
	logic [IdxBits-1:0] rd_addr, map_rd;
	logic [IdxBits-1:0] map_addr;
	logic [CntBits-1:0] k_q;
	logic [IdxBits-1:0] p_q, n0_q, i_q;
	logic up_q;
	logic [TimeBits-1:0] num_q, den_q, rem_q, quo_q;
	logic [5:0] dstep_q;
	logic [1:0] ost_q;
	logic [IdxBits-1:0] oidx_q;
	logic ofnd_q, ovalid_q;
	logic [TimeBits-1:0] dur, ld;
	logic [TimeBits:0] rtry;
	logic [TimeBits+CntBits-1:0] prod;
	logic wr_load;
	logic [IdxBits-1:0] wr_addr;
	logic hold;
	logic [IdxBits-1:0] last_idx;

	assign last_idx = IdxBits'(count_q - 1'b1);
	assign out_valid = ovalid_q;
	assign out_status = ost_q;
	assign out_index = oidx_q;
	assign out_found = ofnd_q;
	assign ld = q_req.b - q_req.a;
	assign rtry = {rem_q, num_q[TimeBits-1]} - {1'b0, den_q};
	assign hold = (t_q >= rd_s) && (t_q <= rd_e);
	assign wr_addr = ready_q ? '0 : count_q[IdxBits-1:0];
	assign prod = (TimeBits+CntBits)'(mapsz_q) * (TimeBits+CntBits)'(dur);

	always_ff @(posedge clk) begin
		if (wr_load) begin
			start_mem[wr_addr] <= q_req.a;
			end_mem[wr_addr] <= q_req.b;
		end
		rd_s <= start_mem[rd_addr];
		rd_e <= end_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MAPCMP && (p_q >= last_idx || rd_e >= bnd_q))
			map_mem[map_addr] <= p_q;
		map_rd <= map_mem[map_addr];
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (q_valid && !ovalid_q) begin
					if (q_req.kind == REQ_LOAD) begin
						state_d = S_OUT;
						if (q_req.last) state_d = S_RD0;
					end else if (!ready_q || count_q == '0) state_d = S_OUT;
					else state_d = S_QRD;
				end
			end
			S_RD0: state_d = (count_q == '0) ? S_OUT : S_RDLAST;
			S_RDLAST: state_d = S_DIV;
			S_DIV: if (dstep_q == 6'(TimeBits)) state_d = S_MAPRD;
			S_MAPRD: state_d = (k_q > mapsz_q) ? S_OUT : S_MAPCMP;
			S_MAPCMP: state_d = S_MAPRD;
			S_QRD: state_d = (mapsz_q == '0) ? S_SRD : S_QDIV;
			S_QDIV: if (dstep_q == 6'(TimeBits + 1)) state_d = S_QMAP;
			S_QMAP: state_d = S_QMAPW;
			S_QMAPW: state_d = S_SRD;
			S_SRD: state_d = S_SCMP;
			S_SCMP: begin
				if (hold) state_d = S_OUT;
				else if (!up_q && i_q == '0) state_d = S_SRD;
				else if (up_q && i_q >= last_idx) state_d = S_OUT;
				else state_d = S_SRD;
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == S_IDLE) && q_valid && !ovalid_q;
		wr_load = q_pop && q_req.kind == REQ_LOAD && q_req.b > q_req.a &&
			!(count_q >= CntBits'(MaxIntervals) && !ready_q);
		rd_addr = i_q;
		case (state_q)
			S_IDLE: rd_addr = '0;
			S_RD0: rd_addr = '0;
			S_RDLAST: rd_addr = last_idx;
			S_MAPRD: rd_addr = p_q;
			S_QRD: rd_addr = '0;
			default: rd_addr = i_q;
		endcase
		map_addr = (state_q == S_MAPCMP) ? IdxBits'(k_q - 1'b1) : IdxBits'(quo_q);
		dur = t_q - s0_q;
	end

	// state registers; divider computes quotient of num by den, bit-serial restoring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			mapsz_q <= '0;
			longest_q <= '0;
			span_q <= '0;
			ready_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && out_ready) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (q_pop) begin
					oidx_q <= '0;
					ofnd_q <= 1'b0;
					if (q_req.kind == REQ_LOAD) begin
						if (ready_q) begin
							ready_q <= 1'b0;
							mapsz_q <= '0;
							span_q <= '0;
						end
						if (q_req.b <= q_req.a) begin
							ost_q <= ST_INVALID;
							if (ready_q) begin
								count_q <= '0;
								longest_q <= '0;
							end
						end else if (count_q >= CntBits'(MaxIntervals) && !ready_q) begin
							ost_q <= ST_FULL;
						end else begin
							ost_q <= ST_OK;
							count_q <= (ready_q ? CntBits'(0) : count_q) + 1'b1;
							if (ready_q || ld > longest_q) longest_q <= ld;
						end
					end else begin
						t_q <= q_req.a;
						ost_q <= (!ready_q || count_q == '0) ? ST_NOMAP : ST_OK;
					end
				end
				S_RDLAST: begin
					s0_q <= rd_s;
					dstep_q <= '0;
				end
				S_DIV: begin
					if (dstep_q == 6'd0) begin
						span_q <= (rd_e > s0_q) ? rd_e - s0_q : '0;
						num_q <= (rd_e > s0_q) ? rd_e - s0_q : '0;
						den_q <= longest_q;
						rem_q <= '0;
						quo_q <= '0;
						dstep_q <= 6'd1;
					end else begin
						if (!rtry[TimeBits]) rem_q <= rtry[TimeBits-1:0];
						else rem_q <= {rem_q[TimeBits-2:0], num_q[TimeBits-1]};
						num_q <= {num_q[TimeBits-2:0], 1'b0};
						quo_q <= {quo_q[TimeBits-2:0], !rtry[TimeBits]};
						dstep_q <= dstep_q + 1'b1;
					end
					if (dstep_q == 6'(TimeBits)) begin
						mapsz_q <= (den_q == '0) ? '0 :
							({quo_q[TimeBits-2:0], !rtry[TimeBits]} > TimeBits'(MaxBuckets)
							? CntBits'(MaxBuckets) : CntBits'({quo_q[TimeBits-2:0],
							!rtry[TimeBits]}));
						k_q <= CntBits'(1);
						p_q <= '0;
						bnd_q <= s0_q + longest_q;
						ready_q <= 1'b1;
					end
				end
				S_MAPCMP: begin
					if (p_q >= last_idx || rd_e >= bnd_q) begin
						k_q <= k_q + 1'b1;
						bnd_q <= bnd_q + longest_q;
						if (p_q < last_idx) p_q <= p_q + 1'b1;
					end else p_q <= p_q + 1'b1;
				end
				S_QRD: begin
					s0_q <= rd_s;
					dstep_q <= '0;
					n0_q <= '0;
					if (mapsz_q == '0) begin
						i_q <= '0;
						up_q <= 1'b0;
					end
				end
				S_QDIV: begin
					// q = floor(mapsz * dur / span) via restoring division; 0 before the start, mapsz-1 at or past the span
					if (dstep_q == 6'd0) begin
						if (t_q < s0_q) begin
							quo_q <= '0;
							dstep_q <= 6'(TimeBits + 1);
						end else if (span_q == '0 || dur >= span_q) begin
							quo_q <= TimeBits'(mapsz_q - 1'b1);
							dstep_q <= 6'(TimeBits + 1);
						end else begin
							num_q <= prod[TimeBits-1:0];
							rem_q <= TimeBits'(prod[TimeBits+CntBits-1:TimeBits]);
							den_q <= span_q;
							quo_q <= '0;
							dstep_q <= 6'd1;
						end
					end else if (dstep_q != 6'(TimeBits + 1)) begin
						if (!rtry[TimeBits]) rem_q <= rtry[TimeBits-1:0];
						else rem_q <= {rem_q[TimeBits-2:0], num_q[TimeBits-1]};
						num_q <= {num_q[TimeBits-2:0], 1'b0};
						quo_q <= {quo_q[TimeBits-2:0], !rtry[TimeBits]};
						dstep_q <= dstep_q + 1'b1;
					end
				end
				S_QMAPW: begin
					n0_q <= (map_rd > last_idx) ? last_idx : map_rd;
					i_q <= (map_rd > last_idx) ? last_idx : map_rd;
					up_q <= 1'b0;
				end
				S_SCMP: begin
					if (hold) begin
						oidx_q <= i_q;
						ofnd_q <= 1'b1;
					end else if (!up_q && i_q == '0) begin
						up_q <= 1'b1;
						i_q <= n0_q;
					end else if (!up_q) i_q <= i_q - 1'b1;
					else i_q <= i_q + 1'b1;
				end
				S_OUT: ovalid_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule

### src/bil_checker.sv
// bucketed interval lookup: port checker and bind
// depends on bucketed_interval_lookup_unit
module bil_checker (
	input logic clk,
	input logic arst_n,
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_found: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[12] |-> m_tdata[1:0] == 2'd0) else $error("found on error");
	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[12] |-> m_tdata[11:2] == 10'd0) else $error("index without hit");
endmodule

bind bucketed_interval_lookup_unit bil_checker u_chk (.clk, .arst_n, .m_tvalid,
	.m_tready, .m_tdata);
